// ===== rtl/sgc_pkg.sv =====
// Shared types and constants for the stereo goniometer and correlation meter.
// Used by sgc_ctrl, sgc_datapath and the top level; depends on nothing.
package sgc_pkg;

    localparam int unsigned SAMPLE_W = 16;

    // 1/sqrt2 in Q0.16 and the smoothing factor 0.16 in Q0.16.
    localparam logic [15:0] INV_SQRT2   = 16'd46341;
    localparam logic [13:0] SMOOTH_COEF = 14'd10486;

    // Limits of the power accumulators.
    localparam logic [42:0]        POW_MAX   = {43{1'b1}};
    localparam logic signed [44:0] CROSS_MAX = 45'sh0_07FF_FFFF_FFFF;
    localparam logic signed [44:0] CROSS_MIN = -45'sh0_0800_0000_0000;

    // Correlation of exactly one in Q2.18.
    localparam logic signed [20:0] CORR_ONE_W = 21'sd262144;
    localparam logic [18:0]        CORR_CAP   = 19'd262144;

    // Division runs 64 bits of numerator plus 18 fraction bits plus the
    // half of both normalising shifts.
    localparam logic [7:0] DIV_BASE = 8'd82;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_PREP,
        ST_NORM,
        ST_SQRT,
        ST_DEN,
        ST_DIV,
        ST_SMUL,
        ST_SUPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic prep;
        logic norm;
        logic sqrt;
        logic den;
        logic div;
        logic smul;
        logic supd;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic zero;
        logic norm_done;
        logic sqrt_last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/sgc_ctrl.sv =====
// Sequencer for the correlation meter: steps one item through the datapath.
// Depends on sgc_pkg for the state, command and status types.
module sgc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  sgc_pkg::status_t  status,
    output sgc_pkg::cmd_t     cmd,
    output logic              in_ready
);

    sgc_pkg::state_t state_reg;
    sgc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sgc_pkg::ST_IDLE: if (in_valid) state_next = sgc_pkg::ST_MUL;
            sgc_pkg::ST_MUL:  state_next = sgc_pkg::ST_ACC;
            sgc_pkg::ST_ACC:
            begin
                state_next = status.last ? sgc_pkg::ST_PREP : sgc_pkg::ST_OUT;
            end
            sgc_pkg::ST_PREP: state_next = sgc_pkg::ST_NORM;
            sgc_pkg::ST_NORM:
            begin
                priority if (status.zero)      state_next = sgc_pkg::ST_SMUL;
                else if (status.norm_done)     state_next = sgc_pkg::ST_SQRT;
                else                           state_next = sgc_pkg::ST_NORM;
            end
            sgc_pkg::ST_SQRT: if (status.sqrt_last) state_next = sgc_pkg::ST_DEN;
            sgc_pkg::ST_DEN:  state_next = sgc_pkg::ST_DIV;
            sgc_pkg::ST_DIV:  if (status.div_done) state_next = sgc_pkg::ST_SMUL;
            sgc_pkg::ST_SMUL: state_next = sgc_pkg::ST_SUPD;
            sgc_pkg::ST_SUPD: state_next = sgc_pkg::ST_OUT;
            sgc_pkg::ST_OUT:  if (status.out_free) state_next = sgc_pkg::ST_IDLE;
            default:          state_next = sgc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        in_ready    = (state_reg == sgc_pkg::ST_IDLE);
        cmd.capture = (state_reg == sgc_pkg::ST_IDLE) && in_valid;
        cmd.mul     = (state_reg == sgc_pkg::ST_MUL);
        cmd.acc     = (state_reg == sgc_pkg::ST_ACC);
        cmd.prep    = (state_reg == sgc_pkg::ST_PREP);
        cmd.norm    = (state_reg == sgc_pkg::ST_NORM) && !status.zero;
        cmd.sqrt    = (state_reg == sgc_pkg::ST_SQRT);
        cmd.den     = (state_reg == sgc_pkg::ST_DEN);
        cmd.div     = (state_reg == sgc_pkg::ST_DIV);
        cmd.smul    = (state_reg == sgc_pkg::ST_SMUL);
        cmd.supd    = (state_reg == sgc_pkg::ST_SUPD);
        cmd.load    = (state_reg == sgc_pkg::ST_OUT) && status.out_free;
    end

endmodule

// ===== rtl/sgc_datapath.sv =====
// Datapath of the correlation meter: products, accumulators, normaliser,
// square roots, restoring divider, smoothing and the output register.
// Depends on sgc_pkg for constants and the command and status types.
module sgc_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  sgc_pkg::cmd_t       cmd,
    input  logic signed [15:0]  sample_l,
    input  logic signed [15:0]  sample_r,
    input  logic                last_frame,
    input  logic                out_ready,
    output sgc_pkg::status_t    status,
    output logic                out_valid,
    output logic signed [15:0]  side_x,
    output logic signed [15:0]  mid_y,
    output logic signed [15:0]  correlation,
    output logic                correlation_valid
);

    // Rounds |d|/sqrt2 half away from zero, puts the sign back, saturates.
    function automatic logic [15:0] scale_sat(input logic [32:0] p, input logic neg);
        logic [33:0] t;
        logic [17:0] r;
        logic [15:0] res;
        t = 34'(p) + 34'd32768;
        r = t[33:16];
        if (neg)
            res = (r > 18'd32768) ? 16'h8000 : 16'(18'd0 - r);
        else
            res = (r > 18'd32767) ? 16'h7FFF : r[15:0];
        return res;
    endfunction

    // Captured item.
    logic signed [15:0] l_reg, r_reg;
    logic               last_reg;

    // Products.
    logic [30:0]        pll_reg, prr_reg;
    logic signed [31:0] plr_reg;
    logic [32:0]        psd_reg, pmd_reg;
    logic               sneg_reg, mneg_reg;
    logic [15:0]        side_reg, mid_reg;

    // Accumulators and smoothed state.
    logic [42:0]        ll_sum_reg, rr_sum_reg;
    logic signed [43:0] cross_sum_reg;
    logic signed [19:0] smooth_reg;

    // Correlation working registers.
    logic [61:0]        work_l_reg, work_r_reg;
    logic [5:0]         sl_reg, sr_reg;
    logic [61:0]        res_l_reg, res_r_reg;
    logic [61:0]        bit_reg;
    logic [63:0]        num_reg;
    logic               cneg_reg;
    logic [61:0]        den_reg;
    logic [61:0]        rem_reg;
    logic [18:0]        q_reg;
    logic [7:0]         cnt_reg;
    logic signed [19:0] inst_reg;
    logic               dneg_reg;
    logic [33:0]        sprod_reg;

    // Output register.
    logic               out_valid_reg;
    logic [15:0]        side_o_reg, mid_o_reg, corr_o_reg;
    logic               cval_o_reg;

    // Combinational terms.
    logic signed [16:0] dif, sum;
    logic [16:0]        dmag, smag;
    logic [43:0]        ll_add, rr_add;
    logic signed [44:0] cross_add;
    logic [43:0]        cross_mag;
    logic [61:0]        t_l, t_r;
    logic               ge_l, ge_r;
    logic [61:0]        den_w;
    logic [62:0]        rem_sh;
    logic               ge_d;
    logic [19:0]        qn;
    logic               capped;
    logic [18:0]        qmag;
    logic signed [20:0] dsm;
    logic [19:0]        dmag_s;
    logic [34:0]        st_t;
    logic [18:0]        step;
    logic signed [20:0] nv;
    logic [18:0]        cmag;
    logic [19:0]        cr_t;
    logic [16:0]        cr;
    logic [15:0]        corr_w;

    always_comb
    begin
        dif  = 17'(l_reg) - 17'(r_reg);
        sum  = 17'(l_reg) + 17'(r_reg);
        dmag = dif[16] ? (~dif + 17'd1) : dif;
        smag = sum[16] ? (~sum + 17'd1) : sum;

        ll_add    = 44'(ll_sum_reg) + 44'(pll_reg);
        rr_add    = 44'(rr_sum_reg) + 44'(prr_reg);
        cross_add = 45'(cross_sum_reg) + 45'(plr_reg);
        cross_mag = cross_sum_reg[43] ? (~cross_sum_reg + 44'd1) : cross_sum_reg;

        t_l  = res_l_reg + bit_reg;
        t_r  = res_r_reg + bit_reg;
        ge_l = (work_l_reg >= t_l);
        ge_r = (work_r_reg >= t_r);
        den_w = res_l_reg[30:0] * res_r_reg[30:0];

        rem_sh = {rem_reg, num_reg[63]};
        ge_d   = (rem_sh >= {1'b0, den_reg});
        qn     = {q_reg, ge_d};
        capped = (qn > 20'(sgc_pkg::CORR_CAP));
        qmag   = capped ? sgc_pkg::CORR_CAP : qn[18:0];

        dsm    = 21'(inst_reg) - 21'(smooth_reg);
        dmag_s = dsm[20] ? 20'(~dsm + 21'd1) : dsm[19:0];
        st_t   = 35'(sprod_reg) + 35'd32768;
        step   = st_t[34:16];
        nv     = dneg_reg ? (21'(smooth_reg) - 21'(step)) : (21'(smooth_reg) + 21'(step));

        cmag = smooth_reg[19] ? 19'(~smooth_reg + 20'd1) : smooth_reg[18:0];
        cr_t = 20'(cmag) + 20'd4;
        cr   = cr_t[19:3];
        if (smooth_reg[19])
            corr_w = (cr > 17'd32768) ? 16'h8000 : 16'(17'd0 - cr);
        else
            corr_w = (cr > 17'd32767) ? 16'h7FFF : cr[15:0];
    end

    always_comb
    begin
        status.last      = last_reg;
        status.zero      = (work_l_reg == '0) || (work_r_reg == '0);
        status.norm_done = (work_l_reg[61:60] != 2'b00) && (work_r_reg[61:60] != 2'b00);
        status.sqrt_last = bit_reg[0];
        status.div_done  = capped || (cnt_reg == 8'd1);
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Accumulators, smoothed state and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ll_sum_reg    <= '0;
            rr_sum_reg    <= '0;
            cross_sum_reg <= '0;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                ll_sum_reg <= ll_add[43] ? sgc_pkg::POW_MAX : ll_add[42:0];
                rr_sum_reg <= rr_add[43] ? sgc_pkg::POW_MAX : rr_add[42:0];
                priority if (cross_add > sgc_pkg::CROSS_MAX)
                    cross_sum_reg <= sgc_pkg::CROSS_MAX[43:0];
                else if (cross_add < sgc_pkg::CROSS_MIN)
                    cross_sum_reg <= sgc_pkg::CROSS_MIN[43:0];
                else
                    cross_sum_reg <= cross_add[43:0];
            end
            else if (cmd.prep)
            begin
                ll_sum_reg    <= '0;
                rr_sum_reg    <= '0;
                cross_sum_reg <= '0;
            end

            if (cmd.supd)
            begin
                priority if (nv > sgc_pkg::CORR_ONE_W)
                    smooth_reg <= sgc_pkg::CORR_ONE_W[19:0];
                else if (nv < -sgc_pkg::CORR_ONE_W)
                    smooth_reg <= 20'(-sgc_pkg::CORR_ONE_W);
                else
                    smooth_reg <= nv[19:0];
            end

            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            l_reg    <= sample_l;
            r_reg    <= sample_r;
            last_reg <= last_frame;
        end

        if (cmd.mul)
        begin
            pll_reg  <= 31'(l_reg * l_reg);
            prr_reg  <= 31'(r_reg * r_reg);
            plr_reg  <= l_reg * r_reg;
            psd_reg  <= 33'(dmag) * 33'(sgc_pkg::INV_SQRT2);
            pmd_reg  <= 33'(smag) * 33'(sgc_pkg::INV_SQRT2);
            sneg_reg <= dif[16];
            mneg_reg <= sum[16];
        end

        if (cmd.acc)
        begin
            side_reg <= scale_sat(psd_reg, sneg_reg);
            mid_reg  <= scale_sat(pmd_reg, mneg_reg);
        end

        if (cmd.prep)
        begin
            work_l_reg <= 62'(ll_sum_reg);
            work_r_reg <= 62'(rr_sum_reg);
            num_reg    <= 64'(cross_mag);
            cneg_reg   <= cross_sum_reg[43];
            sl_reg     <= '0;
            sr_reg     <= '0;
            inst_reg   <= '0;
        end

        if (cmd.norm)
        begin
            if (status.norm_done)
            begin
                res_l_reg <= '0;
                res_r_reg <= '0;
                bit_reg   <= 62'(1) << 60;
            end
            else
            begin
                if (work_l_reg[61:60] == 2'b00)
                begin
                    work_l_reg <= work_l_reg << 2;
                    sl_reg     <= sl_reg + 6'd2;
                end
                if (work_r_reg[61:60] == 2'b00)
                begin
                    work_r_reg <= work_r_reg << 2;
                    sr_reg     <= sr_reg + 6'd2;
                end
            end
        end

        if (cmd.sqrt)
        begin
            if (ge_l)
            begin
                work_l_reg <= work_l_reg - t_l;
                res_l_reg  <= (res_l_reg >> 1) + bit_reg;
            end
            else
            begin
                res_l_reg <= res_l_reg >> 1;
            end
            if (ge_r)
            begin
                work_r_reg <= work_r_reg - t_r;
                res_r_reg  <= (res_r_reg >> 1) + bit_reg;
            end
            else
            begin
                res_r_reg <= res_r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.den)
        begin
            den_reg <= den_w;
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= sgc_pkg::DIV_BASE + 8'((7'(sl_reg) + 7'(sr_reg)) >> 1);
        end

        if (cmd.div)
        begin
            rem_reg <= ge_d ? 62'(rem_sh - {1'b0, den_reg}) : rem_sh[61:0];
            q_reg   <= qn[18:0];
            num_reg <= num_reg << 1;
            cnt_reg <= cnt_reg - 8'd1;
            if (status.div_done)
                inst_reg <= cneg_reg ? -20'(qmag) : 20'(qmag);
        end

        if (cmd.smul)
        begin
            dneg_reg  <= dsm[20];
            sprod_reg <= 34'(dmag_s) * 34'(sgc_pkg::SMOOTH_COEF);
        end

        if (cmd.load)
        begin
            side_o_reg <= side_reg;
            mid_o_reg  <= mid_reg;
            corr_o_reg <= corr_w;
            cval_o_reg <= last_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign side_x            = side_o_reg;
    assign mid_y             = mid_o_reg;
    assign correlation       = corr_o_reg;
    assign correlation_valid = cval_o_reg;

endmodule

// ===== rtl/stereo_goniometer_correlation.sv =====
// Top level of the stereo goniometer and phase-correlation meter.
// Instantiates sgc_ctrl and sgc_datapath; depends on sgc_pkg.
//
// Usage: each input item is one stereo frame (sample_l, sample_r, last_frame)
// offered on in_valid/in_ready. Every item yields exactly one result item on
// out_valid/out_ready: the goniometer point side_x, mid_y and the smoothed
// correlation, with correlation_valid set on the frame that closes a chunk.
// Timing: an ordinary frame goes through the products, accumulation and load
// steps before its result reaches the result register, and in_ready is high
// again in the cycle the result appears; no new frame is taken before then.
// A closing frame additionally runs the correlation: a set-up step, the
// normalising shifts, the paired square-root unit, one multiply, then the
// restoring divider at one quotient bit per cycle, ending early once the
// quotient exceeds one, then the smoothing multiply and update. A chunk with a
// silent channel skips the roots and the divider.
// The single result register lets a new frame be accepted while the previous
// result still waits; if the receiver stalls, the finished item waits in the
// sequencer until that register frees. Reset clears the power sums and the
// smoothed correlation and empties the result register.
module stereo_goniometer_correlation
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  sample_l,
    input  logic signed [15:0]  sample_r,
    input  logic                last_frame,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  side_x,
    output logic signed [15:0]  mid_y,
    output logic signed [15:0]  correlation,
    output logic                correlation_valid
);

    sgc_pkg::cmd_t    cmd;
    sgc_pkg::status_t status;

    sgc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    sgc_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sample_l          (sample_l),
        .sample_r          (sample_r),
        .last_frame        (last_frame),
        .out_ready         (out_ready),
        .status            (status),
        .out_valid         (out_valid),
        .side_x            (side_x),
        .mid_y             (mid_y),
        .correlation       (correlation),
        .correlation_valid (correlation_valid)
    );

    // One frame is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("frame accepted while another is in progress");

    // A result only appears after the sequencer has been busy with a frame.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a frame being processed");

    // A new result is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid || out_ready))
        else $error("result register overwritten while stalled");

endmodule

// ===== test/stereo_goniometer_correlation_tb.sv =====
// Testbench for the stereo goniometer and phase-correlation meter.
// Drives frames through the valid/ready handshake and compares every result
// with a bit-accurate predictor kept in a scoreboard class; needs only the RTL.
module stereo_goniometer_correlation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One goniometer result item as predicted for a frame.
    typedef struct {
        logic signed [15:0] side;
        logic signed [15:0] mid;
        logic signed [15:0] corr;
        logic               corr_upd;
    } gonio_point_t;

    // Scoreboard: holds its own copy of the power sums and the smoothed
    // correlation, and a queue of predicted points in acceptance order.
    class gonio_scoreboard;
        logic [42:0]        left_pow;
        logic [42:0]        right_pow;
        logic signed [43:0] cross_pow;
        logic signed [19:0] smooth_corr;
        gonio_point_t       pending[$];
        int                 errors;

        function new();
            left_pow    = '0;
            right_pow   = '0;
            cross_pow   = '0;
            smooth_corr = '0;
            errors      = 0;
        endfunction

        // Scales a difference or sum by 1/sqrt2, rounding half away from zero.
        function logic signed [15:0] scale_point(longint d);
            longint m;
            longint r;
            m = (d < 0) ? -d : d;
            r = (m * 46341 + 32768) >>> 16;
            if (d < 0)
                return (r > 32768) ? -16'sd32768 : 16'(-r);
            return (r > 32767) ? 16'sd32767 : 16'(r);
        endfunction

        function logic [63:0] floor_root(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Normalises by even shifts into [2^60, 2^62) before the root.
        function logic [63:0] norm_root(logic [63:0] x, output int unsigned sh);
            sh = 0;
            while (x < (64'd1 << 60))
            begin
                x  = x << 2;
                sh = sh + 2;
            end
            return floor_root(x);
        endfunction

        // floor(num * 2^k / den), capped at cap; same bit-serial order as the divider.
        function logic [63:0] capped_quotient(logic [63:0] num, int unsigned k,
                                              logic [63:0] den, logic [63:0] cap);
            logic [63:0] rem;
            logic [63:0] q;
            logic        b;
            rem = 0;
            q   = 0;
            for (int unsigned i = 0; i < 64 + k; i++)
            begin
                b   = (i < 64) ? num[63 - i] : 1'b0;
                rem = {rem[62:0], b};
                q   = q << 1;
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
                if (q > cap)
                    return cap;
            end
            return q;
        endfunction

        function longint chunk_correlation();
            int unsigned sl;
            int unsigned sr;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] num;
            logic [63:0] mag;
            longint      c;
            if (left_pow == 0 || right_pow == 0)
                return 0;
            a   = norm_root(64'(left_pow), sl);
            b   = norm_root(64'(right_pow), sr);
            c   = longint'(cross_pow);
            num = (c < 0) ? 64'(-c) : 64'(c);
            mag = capped_quotient(num, 18 + (sl + sr) / 2, a * b, 64'd262144);
            return (c < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        // Notes an accepted frame and queues the point it must produce.
        function void note_frame(logic signed [15:0] l, logic signed [15:0] r,
                                 logic last);
            gonio_point_t p;
            longint       li;
            longint       ri;
            longint       acc;
            longint       d;
            longint       m;
            longint       stp;
            longint       s;
            li = l;
            ri = r;
            p.side = scale_point(li - ri);
            p.mid  = scale_point(li + ri);

            acc = longint'(left_pow) + li * li;
            left_pow = (acc > longint'(sgc_pkg::POW_MAX)) ? sgc_pkg::POW_MAX : 43'(acc);
            acc = longint'(right_pow) + ri * ri;
            right_pow = (acc > longint'(sgc_pkg::POW_MAX)) ? sgc_pkg::POW_MAX : 43'(acc);
            acc = longint'(cross_pow) + li * ri;
            if (acc > longint'(sgc_pkg::CROSS_MAX))
                acc = longint'(sgc_pkg::CROSS_MAX);
            if (acc < longint'(sgc_pkg::CROSS_MIN))
                acc = longint'(sgc_pkg::CROSS_MIN);
            cross_pow = 44'(acc);

            s = smooth_corr;
            if (last)
            begin
                d   = chunk_correlation() - s;
                m   = (d < 0) ? -d : d;
                stp = (m * 10486 + 32768) >>> 16;
                s   = s + ((d < 0) ? -stp : stp);
                if (s > 262144)
                    s = 262144;
                if (s < -262144)
                    s = -262144;
                smooth_corr = 20'(s);
                left_pow  = '0;
                right_pow = '0;
                cross_pow = '0;
            end

            m = (s < 0) ? -s : s;
            m = (m + 4) >>> 3;
            if (s < 0)
                p.corr = 16'(-((m > 32768) ? 32768 : m));
            else
                p.corr = 16'((m > 32767) ? 32767 : m);
            p.corr_upd = last;
            pending.push_back(p);
        endfunction

        // Compares a result item with the oldest prediction.
        function void check_point(logic signed [15:0] side, logic signed [15:0] mid,
                                  logic signed [15:0] corr, logic corr_upd);
            gonio_point_t p;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result side=%0d mid=%0d corr=%0d",
                         $realtime, side, mid, corr);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (side !== p.side)
            begin
                $display("%0t: side_x expected %0d actual %0d", $realtime, p.side, side);
                errors++;
            end
            if (mid !== p.mid)
            begin
                $display("%0t: mid_y expected %0d actual %0d", $realtime, p.mid, mid);
                errors++;
            end
            if (corr !== p.corr)
            begin
                $display("%0t: correlation expected %0d actual %0d",
                         $realtime, p.corr, corr);
                errors++;
            end
            if (corr_upd !== p.corr_upd)
            begin
                $display("%0t: correlation_valid expected %0b actual %0b",
                         $realtime, p.corr_upd, corr_upd);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] sample_l;
    logic signed [15:0] sample_r;
    logic               last_frame;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] side_x;
    logic signed [15:0] mid_y;
    logic signed [15:0] correlation;
    logic               correlation_valid;

    gonio_scoreboard board;
    int  send_idle_pct;   // chance per cycle that the sender holds back
    int  recv_idle_pct;   // chance per cycle that the receiver stalls
    int  frames_sent;
    longint cycle_count;

    stereo_goniometer_correlation u_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample_l          (sample_l),
        .sample_r          (sample_r),
        .last_frame        (last_frame),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .side_x            (side_x),
        .mid_y             (mid_y),
        .correlation       (correlation),
        .correlation_valid (correlation_valid)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The receiver side: ready is redrawn every cycle, independent of valid.
    // Results are sampled at the edge, before the nonblocking updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_point(side_x, mid_y, correlation, correlation_valid);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog. The slowest frame is a closing one: it adds the correlation
    // work to any receiver stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 800000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one frame and holds it until accepted. Random idle cycles are
    // inserted before the frame, never while valid is high. Valid is left
    // high after acceptance so that back-to-back frames follow directly.
    task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample_l   <= l;
        sample_r   <= r;
        last_frame <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_frame(l, r, last);
        frames_sent++;
    endtask

    // Draws a sample: mostly uniform, sometimes an extreme or near silence.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // A chunk of frames: right is a copy, an inverted or a scaled copy of left,
    // silent, or drawn independently, so the correlation travels across its whole range.
    task automatic send_chunk(int len);
        int mode;
        logic signed [15:0] l;
        logic signed [15:0] r;
        mode = $urandom_range(5);
        for (int i = 0; i < len; i++)
        begin
            l = pick_sample();
            case (mode)
                0: r = l;
                1: r = (l == -16'sd32768) ? 16'sd32767 : -l;
                2: r = l >>> 2;
                3: r = 16'sd0;
                default: r = pick_sample();
            endcase
            send_frame(l, r, i == len - 1);
        end
    endtask

    task automatic random_phase(int frames);
        int target;
        target = frames_sent + frames;
        while (frames_sent < target)
        begin
            if ($urandom_range(9) == 0)
                send_chunk($urandom_range(60, 200));
            else
                send_chunk($urandom_range(1, 16));
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample_l      = '0;
        sample_r      = '0;
        last_frame    = 1'b0;
        out_ready     = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 80;
        frames_sent   = 0;
        cycle_count   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: sample extremes, a silent chunk, a one-sided chunk,
        // fully in-phase and anti-phase chunks, and one that clamps at one.
        send_frame(16'sd0, 16'sd0, 1'b1);
        send_frame(-16'sd32768, 16'sd32767, 1'b0);
        send_frame(16'sd32767, -16'sd32768, 1'b0);
        send_frame(-16'sd32768, -16'sd32768, 1'b0);
        send_frame(16'sd32767, 16'sd32767, 1'b1);
        send_frame(16'sd1234, 16'sd0, 1'b0);
        send_frame(-16'sd5, 16'sd0, 1'b1);
        send_frame(16'sd0, 16'sd32767, 1'b1);
        send_frame(16'sd1, 16'sd1, 1'b1);
        send_frame(16'sd1, -16'sd1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_frame(16'sd20000, 16'sd20000, i == 3);
        for (int i = 0; i < 4; i++)
            send_frame(-16'sd32768, 16'sd32767, i == 3);
        send_frame(16'sd3, 16'sd7, 1'b0);
        send_frame(-16'sd9000, 16'sd11000, 1'b1);
        send_frame(16'sd1, 16'sd0, 1'b0);
        send_frame(16'sd0, 16'sd1, 1'b1);

        random_phase(380);
        send_idle_pct = 80;
        recv_idle_pct = 12;
        random_phase(380);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(370);
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        // Allow any stray result to surface before closing.
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sgc_pkg.sv
rtl/sgc_ctrl.sv
rtl/sgc_datapath.sv
rtl/stereo_goniometer_correlation.sv
test/stereo_goniometer_correlation_tb.sv
